### rtl/regret_matching_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Regret matching table unit: assertion macros
// Concurrent checks on clk with rst_n as disable, dropped under SYNTH.
// ---------------------------------------------------------------------------
`ifndef REGRET_MATCHING_TABLE_UNIT_MACROS_SVH
`define REGRET_MATCHING_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define RMT_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RMT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMT_ASSERT_ALWAYS(name, cond, msg)
`define RMT_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### rtl/rmt_pkg.sv
// ---------------------------------------------------------------------------
// rmt_pkg
// Shared types, codes and helpers of the regret matching table unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rmt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 4096;
    localparam int DEFAULT_MAX_ACTIONS = 16;

    // Width of a signed set total: sixteen signed Q16.16 words
    localparam int TW     = 37;
    localparam int Q_BITS = 16;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] OP_ADD_REGRET   = 3'd0;
    localparam logic [2:0] OP_ADD_STRATEGY = 3'd1;
    localparam logic [2:0] OP_READ_REGRET  = 3'd2;
    localparam logic [2:0] OP_READ_AVERAGE = 3'd3;
    localparam logic [2:0] OP_SAMPLE       = 3'd4;

    localparam logic SEL_REGRET   = 1'b0;
    localparam logic SEL_STRATEGY = 1'b1;

    typedef struct packed {
        logic rd;
        logic wr;
        logic sel;
    } store_ctrl_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return s[31:0];
    endfunction

    // floor(65536 / n) for n from 1 to 16
    function automatic logic [16:0] uniform_q16(input logic [4:0] n);
        case (n)
            5'd1:    return 17'd65536;
            5'd2:    return 17'd32768;
            5'd3:    return 17'd21845;
            5'd4:    return 17'd16384;
            5'd5:    return 17'd13107;
            5'd6:    return 17'd10922;
            5'd7:    return 17'd9362;
            5'd8:    return 17'd8192;
            5'd9:    return 17'd7281;
            5'd10:   return 17'd6553;
            5'd11:   return 17'd5957;
            5'd12:   return 17'd5461;
            5'd13:   return 17'd5041;
            5'd14:   return 17'd4681;
            5'd15:   return 17'd4369;
            default: return 17'd4096;
        endcase
    endfunction

endpackage

### rtl/regret_matching_table_unit.sv
// ---------------------------------------------------------------------------
// regret_matching_table_unit
// Regret and strategy sum tables with regret matching reads and sampling.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser     | tlast
//  s_*     | in  | base, count, slot, amount, draw        | operation | -
//  m_*     | out | action_number, probability             | -         | last_result
//
//  One item at a time. Each item first checks its base in ST_MOD, subtracting
//  TABLE_DEPTH while the base is at or above it (never at the default depth).
//  An add then reads and writes back the entry. A read walks the set twice
//  through the single memory port: once to total the entries, then once to
//  give each probability, using the divider where needed; a sample stops at
//  the picked action. After reset a clearing pass zeroes both stores with
//  s_tready low. A stalled result holds the walk until m_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "regret_matching_table_unit_macros.svh"
module regret_matching_table_unit #(
    parameter int TABLE_DEPTH = rmt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int MAX_ACTIONS = rmt_pkg::DEFAULT_MAX_ACTIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // base_index[11:0], action_count[16:12], action_slot[20:17],
    // amount[52:21], random_draw[68:53], zero[71:69]
    input  logic [71:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // action_number[3:0], probability[20:4], zero[23:21]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import rmt_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CW     = ((ADDR_W > 12) ? ADDR_W : 12) + 1;
    localparam int LIM    = (MAX_ACTIONS < 16) ? MAX_ACTIONS : 16;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MOD       = 4'd1;
    localparam logic [3:0] ST_RMW_RD    = 4'd2;
    localparam logic [3:0] ST_RMW_WR    = 4'd3;
    localparam logic [3:0] ST_SUM_RD    = 4'd4;
    localparam logic [3:0] ST_SUM_ACC   = 4'd5;
    localparam logic [3:0] ST_PROB_RD   = 4'd6;
    localparam logic [3:0] ST_PROB_EVAL = 4'd7;
    localparam logic [3:0] ST_DIV       = 4'd8;
    localparam logic [3:0] ST_EMIT      = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [CW-1:0]        base_reg, base_next;
    logic [4:0]           count_reg, count_next;
    logic [3:0]           slot_reg, slot_next;
    logic [31:0]          amount_reg, amount_next;
    logic [15:0]          draw_reg, draw_next;
    logic [3:0]           idx_reg, idx_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic signed [TW-1:0] total_reg, total_next;
    logic [16:0]          prob_reg, prob_next;
    logic [20:0]          cum_reg, cum_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_act_reg, out_act_next;
    logic [16:0]          out_prob_reg, out_prob_next;
    logic                 out_last_reg, out_last_next;

    store_ctrl_t          st_ctrl;
    logic [31:0]          st_rdata;
    logic                 st_busy;
    logic                 div_start;
    logic [15:0]          div_q;
    logic                 div_done;

    logic [4:0]           raw_count;
    logic [4:0]           eff_count;
    logic [CW-1:0]        slot_sum;
    logic [ADDR_W-1:0]    addr_inc;
    logic signed [TW-1:0] entry_ext;
    logic                 is_last;
    logic [20:0]          cum_sum;
    logic                 emit_now;
    logic                 out_free;

    rmt_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (st_ctrl),
        .addr  (addr_reg),
        .wdata (sat_add32(st_rdata, amount_reg)),
        .rdata (st_rdata),
        .busy  (st_busy)
    );

    rmt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (st_rdata),
        .den      (total_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    assign raw_count = s_tdata[16:12];
    assign eff_count = (raw_count == 5'd0) ? 5'd1 :
                       ((raw_count > 5'(LIM)) ? 5'(LIM) : raw_count);
    assign slot_sum  = base_reg + CW'(slot_reg);
    assign addr_inc  = (addr_reg == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign entry_ext = TW'(signed'(st_rdata));
    assign is_last   = ({1'b0, idx_reg} == count_reg - 5'd1);
    assign cum_sum   = cum_reg + 21'(prob_reg);
    assign emit_now  = (op_reg != OP_SAMPLE) || (21'(draw_reg) < cum_sum) || is_last;
    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE) && !st_busy;

    always_comb
    begin
        st_ctrl.rd  = (state_reg == ST_RMW_RD) || (state_reg == ST_SUM_RD) ||
                      (state_reg == ST_PROB_RD);
        st_ctrl.wr  = (state_reg == ST_RMW_WR);
        st_ctrl.sel = ((op_reg == OP_ADD_STRATEGY) || (op_reg == OP_READ_AVERAGE)) ?
                      SEL_STRATEGY : SEL_REGRET;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        amount_next    = amount_reg;
        draw_next      = draw_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        total_next     = total_reg;
        prob_next      = prob_reg;
        cum_next       = cum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_act_next   = out_act_reg;
        out_prob_next  = out_prob_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next     = s_tuser;
                    base_next   = CW'(s_tdata[11:0]);
                    count_next  = eff_count;
                    slot_next   = s_tdata[20:17];
                    amount_next = s_tdata[52:21];
                    draw_next   = s_tdata[68:53];
                    // unused codes leave no trace
                    if (s_tuser <= OP_SAMPLE)
                        state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (base_reg >= CW'(TABLE_DEPTH))
                    base_next = base_reg - CW'(TABLE_DEPTH);
                else
                begin
                    case (op_reg) inside
                        OP_ADD_REGRET, OP_ADD_STRATEGY:
                        begin
                            if ({1'b0, slot_reg} < count_reg)
                            begin
                                addr_next  = (slot_sum >= CW'(TABLE_DEPTH)) ?
                                             ADDR_W'(slot_sum - CW'(TABLE_DEPTH)) :
                                             ADDR_W'(slot_sum);
                                state_next = ST_RMW_RD;
                            end
                            else
                                state_next = ST_IDLE;
                        end
                        default:
                        begin
                            addr_next  = ADDR_W'(base_reg);
                            idx_next   = '0;
                            total_next = '0;
                            state_next = ST_SUM_RD;
                        end
                    endcase
                end
            end
            ST_RMW_RD:
                state_next = ST_RMW_WR;
            ST_RMW_WR:
                state_next = ST_IDLE;
            ST_SUM_RD:
                state_next = ST_SUM_ACC;
            ST_SUM_ACC:
            begin
                // regret totals count positive entries only
                if (op_reg == OP_READ_AVERAGE || !st_rdata[31] && st_rdata != 32'd0)
                    total_next = total_reg + entry_ext;
                if (is_last)
                begin
                    idx_next   = '0;
                    addr_next  = ADDR_W'(base_reg);
                    cum_next   = '0;
                    state_next = ST_PROB_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    addr_next  = addr_inc;
                    state_next = ST_SUM_RD;
                end
            end
            ST_PROB_RD:
                state_next = ST_PROB_EVAL;
            ST_PROB_EVAL:
            begin
                state_next = ST_EMIT;
                if (total_reg <= 0)
                    prob_next = uniform_q16(count_reg);
                else if (st_rdata[31] || st_rdata == 32'd0)
                    prob_next = '0;
                else if (entry_ext >= total_reg)
                    prob_next = ONE_Q16;
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    prob_next  = {1'b0, div_q};
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_now)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_act_next   = idx_reg;
                        out_prob_next  = prob_reg;
                        out_last_next  = (op_reg == OP_SAMPLE) || is_last;
                        if (op_reg == OP_SAMPLE || is_last)
                            state_next = ST_IDLE;
                        else
                        begin
                            idx_next   = idx_reg + 4'd1;
                            addr_next  = addr_inc;
                            state_next = ST_PROB_RD;
                        end
                    end
                end
                else
                begin
                    cum_next   = cum_sum;
                    idx_next   = idx_reg + 4'd1;
                    addr_next  = addr_inc;
                    state_next = ST_PROB_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        base_reg     <= base_next;
        count_reg    <= count_next;
        slot_reg     <= slot_next;
        amount_reg   <= amount_next;
        draw_reg     <= draw_next;
        idx_reg      <= idx_next;
        addr_reg     <= addr_next;
        total_reg    <= total_next;
        prob_reg     <= prob_next;
        cum_reg      <= cum_next;
        out_act_reg  <= out_act_next;
        out_prob_reg <= out_prob_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_prob_reg, out_act_reg};
    assign m_tlast  = out_last_reg;

    `RMT_ASSERT_ALWAYS(a_no_accept_while_clearing, !(s_tready && st_busy), "word accepted during clear")
    `RMT_ASSERT_ALWAYS(a_single_port, !(st_ctrl.rd && st_ctrl.wr), "read and write in one cycle")
    `RMT_ASSERT_NEXT(a_div_latency, div_start, !div_done, "divider finished too early")
    `RMT_ASSERT_ALWAYS(a_div_idle_start, !(div_start && state_reg == ST_DIV), "divider restarted")

endmodule

### rtl/rmt_store.sv
// ---------------------------------------------------------------------------
// rmt_store
// Regret and strategy memories with a registered read and a clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmt_store #(
    parameter int DEPTH  = rmt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(rmt_pkg::DEFAULT_TABLE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmt_pkg::store_ctrl_t ctrl,
    input  logic [ADDR_W-1:0]    addr,
    input  logic [31:0]          wdata,
    output logic [31:0]          rdata,
    output logic                 busy
);
    import rmt_pkg::*;

    logic [31:0]       regret_mem [DEPTH];
    logic [31:0]       strat_mem  [DEPTH];
    logic [31:0]       reg_rd_reg;
    logic [31:0]       str_rd_reg;
    logic              sel_q_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                busy_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            regret_mem[clr_addr_reg] <= '0;
            strat_mem[clr_addr_reg]  <= '0;
        end
        else if (ctrl.wr)
        begin
            if (ctrl.sel == SEL_STRATEGY)
                strat_mem[addr] <= wdata;
            else
                regret_mem[addr] <= wdata;
        end
        if (ctrl.rd)
        begin
            reg_rd_reg <= regret_mem[addr];
            str_rd_reg <= strat_mem[addr];
            sel_q_reg  <= ctrl.sel;
        end
    end

    assign rdata = (sel_q_reg == SEL_STRATEGY) ? str_rd_reg : reg_rd_reg;
    assign busy  = busy_reg;

endmodule

### rtl/rmt_divider.sv
// ---------------------------------------------------------------------------
// rmt_divider
// Restoring divider: floor(num * 65536 / den) for 0 < num < den, one bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmt_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           num,
    input  logic [rmt_pkg::TW-1:0] den,
    output logic [15:0]           quotient,
    output logic                  done
);
    import rmt_pkg::*;

    logic [TW-1:0] rem_reg;
    logic [TW-1:0] den_reg;
    logic [15:0]   q_reg;
    logic [4:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [TW-1:0] rem_dbl;
    logic          fits;

    assign rem_dbl = {rem_reg[TW-2:0], 1'b0};
    assign fits    = rem_dbl >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(Q_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= TW'(num);
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_dbl - den_reg : rem_dbl;
            q_reg   <= {q_reg[14:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

### tb/sv/regret_matching_table_unit_tb.sv
// ---------------------------------------------------------------------------
// regret_matching_table_unit_tb
// Drives add, read, sample and unused-code words into the regret matching table unit
// and checks every result word against a local model of both stores.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module regret_matching_table_unit_tb;
    import rmt_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int CYC_LIMIT = 2000000;

    // codes the block ignores
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [3:0]  action_number;
        logic [16:0] probability;
        logic        last_result;
    } prob_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic signed [31:0] regret_model [DEPTH];
    logic signed [31:0] strat_model [DEPTH];
    prob_word_t         pending_probs [$];
    int                 error_count = 0;
    int                 result_count = 0;
    int                 item_count = 0;
    int                 cycle_count = 0;
    bit                 hold_off = 1'b0;
    bit                 no_idle = 1'b0;

    regret_matching_table_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch at result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    function automatic logic [16:0] q16_ratio(input longint num, input longint den);
        if (num <= 0 || den <= 0)
            return 17'd0;
        if (num >= den)
            return 17'd65536;
        return 17'((num * 65536) / den);
    endfunction

    // Probabilities of one information set from either store
    function automatic void set_probs(input bit avg, input int base, input int n,
                                      output logic [16:0] p [16]);
        longint total;
        longint v;
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            v = avg ? strat_model[(base + i) % DEPTH] : regret_model[(base + i) % DEPTH];
            if (avg || v > 0)
                total += v;
        end
        for (int i = 0; i < n; i++)
        begin
            v = avg ? strat_model[(base + i) % DEPTH] : regret_model[(base + i) % DEPTH];
            p[i] = (total > 0) ? q16_ratio(v, total) : 17'(65536 / n);
        end
    endfunction

    function automatic void predict(input logic [2:0] op, input logic [11:0] base,
                                    input logic [4:0] cnt, input logic [3:0] slot,
                                    input logic [31:0] amt, input logic [15:0] draw);
        int n;
        int a;
        int pick;
        int cum;
        longint s;
        logic [16:0] p [16];
        prob_word_t w;
        n = (cnt == 0) ? 1 : ((cnt > 16) ? 16 : int'(cnt));
        case (op)
            OP_ADD_REGRET, OP_ADD_STRATEGY:
            begin
                if (slot < n)
                begin
                    a = (base + slot) % DEPTH;
                    s = (op == OP_ADD_REGRET) ? longint'(regret_model[a]) :
                                                longint'(strat_model[a]);
                    s += longint'($signed(amt));
                    if (s > 64'sd2147483647) s = 64'sd2147483647;
                    if (s < -64'sd2147483648) s = -64'sd2147483648;
                    if (op == OP_ADD_REGRET) regret_model[a] = 32'(s);
                    else strat_model[a] = 32'(s);
                end
            end
            OP_READ_REGRET, OP_READ_AVERAGE:
            begin
                set_probs(op == OP_READ_AVERAGE, base, n, p);
                for (int i = 0; i < n; i++)
                begin
                    w = '{4'(i), p[i], i == n - 1};
                    pending_probs.insert(pending_probs.size(), w);
                end
            end
            OP_SAMPLE:
            begin
                set_probs(1'b0, base, n, p);
                pick = n - 1;
                cum = 0;
                for (int i = 0; i < n; i++)
                begin
                    cum += p[i];
                    if (draw < cum)
                    begin
                        pick = i;
                        break;
                    end
                end
                w = '{4'(pick), p[pick], 1'b1};
                pending_probs.insert(pending_probs.size(), w);
            end
            default: ;
        endcase
    endfunction

    // Offer one word; valid stays up after acceptance until the next negedge
    task automatic send_word(input logic [2:0] op, input logic [11:0] base,
                             input logic [4:0] cnt, input logic [3:0] slot,
                             input logic [31:0] amt, input logic [15:0] draw);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {3'b0, draw, amt, slot, cnt, base};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict(op, base, cnt, slot, amt, draw);
        item_count++;
    endtask

    // Receiver: random stall per word, or a long hold when asked
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            gap = no_idle ? 0 : $urandom_range(0, 12);
            if (gap != 0 || hold_off)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (hold_off) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        prob_word_t got;
        prob_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[3:0], m_tdata[20:4], m_tlast};
            if (pending_probs.size() == 0)
            begin
                $display("Unexpected result word %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_probs.pop_front();
                if (got.action_number != want.action_number)
                    report_mismatch("action_number", got.action_number, want.action_number);
                if (got.probability != want.probability)
                    report_mismatch("probability", got.probability, want.probability);
                if (got.last_result != want.last_result)
                    report_mismatch("last_result", got.last_result, want.last_result);
            end
            result_count++;
        end
    end

    // Drop valid, then wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_probs.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(OP_READ_REGRET, 12'd0, 5'd16, 4'd0, 32'd0, 16'd0);
        send_word(OP_READ_AVERAGE, 12'd4095, 5'd0, 4'd0, 32'd0, 16'd0);
        send_word(OP_ADD_REGRET, 12'd4090, 5'd31, 4'd15, 32'h7FFF_FFFF, 16'd0);
        send_word(OP_ADD_REGRET, 12'd4090, 5'd16, 4'd15, 32'h7FFF_FFFF, 16'd0);
        send_word(OP_ADD_REGRET, 12'd4090, 5'd16, 4'd3, 32'h0001_0000, 16'd0);
        send_word(OP_ADD_REGRET, 12'd4090, 5'd4, 4'd5, 32'h0100_0000, 16'd0);
        send_word(OP_READ_REGRET, 12'd4090, 5'd16, 4'd0, 32'd0, 16'd0);
        send_word(OP_SAMPLE, 12'd4090, 5'd16, 4'd0, 32'd0, 16'hFFFF);
        send_word(OP_SAMPLE, 12'd4090, 5'd16, 4'd0, 32'd0, 16'd0);
        send_word(OP_ADD_REGRET, 12'd100, 5'd2, 4'd0, 32'h8000_0000, 16'd0);
        send_word(OP_ADD_REGRET, 12'd100, 5'd2, 4'd0, 32'h8000_0000, 16'd0);
        send_word(OP_SAMPLE, 12'd100, 5'd2, 4'd0, 32'd0, 16'h8000);
        send_word(OP_ADD_STRATEGY, 12'd200, 5'd3, 4'd0, 32'h0003_0000, 16'd0);
        send_word(OP_ADD_STRATEGY, 12'd200, 5'd3, 4'd1, 32'hFFFF_0000, 16'd0);
        send_word(OP_ADD_STRATEGY, 12'd200, 5'd3, 4'd2, 32'h0000_0001, 16'd0);
        send_word(OP_READ_AVERAGE, 12'd200, 5'd3, 4'd0, 32'd0, 16'd0);
        send_word(OP_ADD_STRATEGY, 12'd300, 5'd2, 4'd1, 32'hFFFF_FFFF, 16'd0);
        send_word(OP_READ_AVERAGE, 12'd300, 5'd2, 4'd0, 32'd0, 16'd0);
        send_word(OP_UNUSED_LO, 12'd0, 5'd1, 4'd0, 32'h7FFF_FFFF, 16'd0);
        send_word(OP_UNUSED_HI, 12'hFFF, 5'd1, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_READ_REGRET, 12'd0, 5'd1, 4'd0, 32'd0, 16'd0);
        wait_drained();
    endtask

    // Training-like rounds mostly on a few sets: a random mix of adds, reads, samples and other codes
    task automatic test_random(input int items);
        int r;
        logic [11:0] base;
        logic [4:0]  cnt;
        for (int k = 0; k < items; k++)
        begin
            base = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'(4088 + $urandom_range(0, 7));
            cnt  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
            r = $urandom_range(0, 19);
            if (r < 8)
                send_word(r < 5 ? OP_ADD_REGRET : OP_ADD_STRATEGY, base, cnt,
                          4'($urandom_range(0, 5)),
                          ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom >> 12)
                          - 32'h0004_0000, 16'($urandom));
            else if (r < 18)
                send_word(3'($urandom_range(OP_READ_REGRET, OP_SAMPLE)), base, cnt,
                          4'($urandom), 32'($urandom), 16'($urandom));
            else
                send_word(3'($urandom_range(0, 7)), 12'($urandom), 5'($urandom),
                          4'($urandom), 32'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            repeat (600) @(posedge clk);
            for (int k = 0; k < 4; k++)
                send_word(OP_READ_REGRET, 12'(4088 + k), 5'd16, 4'd0, 32'd0, 16'd0);
        join_any
        hold_off = 1'b0;
        wait fork;
        wait_drained();
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random(15);
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            regret_model[i] = 0;
            strat_model[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(75);
        test_backpressure();
        test_no_idle();
        wait_drained();
        repeat (400) @(posedge clk);
        $display("Sent %0d words covering adds, reads, samples and unused codes; %0d results.",
                 item_count, result_count);
        if (error_count == 0 && pending_probs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
